>>> rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // Component and hue formats
    localparam int COMPONENT_BITS    = 8;
    localparam int HUE_FRACTION_BITS = 6;
    localparam int HUE_BITS          = 9 + HUE_FRACTION_BITS;
    // Hue quotient bits: the fraction never exceeds 60 degrees
    localparam int HUE_QUOT_BITS     = 6 + HUE_FRACTION_BITS;

    // Sector of the largest component
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_BITS-1:0]       hue;
        logic [COMPONENT_BITS-1:0] saturation;
        logic [COMPONENT_BITS-1:0] brightness;
    } t_hsv;

    // Side information that travels alongside the dividers
    typedef struct packed {
        logic                      grey;
        t_sector                   sector;
        logic                      neg;
        logic [COMPONENT_BITS-1:0] max_c;
    } t_tag;

endpackage

>>> rtl/rgbhsv_div.sv
module rgbhsv_div #(
    parameter int CB_W = rgbhsv_pkg::COMPONENT_BITS,
    parameter int QS_W = rgbhsv_pkg::COMPONENT_BITS,
    parameter int QH_W = rgbhsv_pkg::HUE_QUOT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [CB_W+QS_W-1:0]   i_num_sat,
    input  logic [CB_W-1:0]        i_den_sat,
    input  logic [CB_W+QH_W-1:0]   i_num_hue,
    input  logic [CB_W-1:0]        i_den_hue,
    input  rgbhsv_pkg::t_tag       i_tag,
    output logic                   o_valid,
    output logic [QS_W-1:0]        o_quot_sat,
    output logic [QH_W-1:0]        o_quot_hue,
    output rgbhsv_pkg::t_tag       o_tag
);
    import rgbhsv_pkg::*;

    localparam int DEPTH = (QS_W > QH_W) ? QS_W : QH_W;
    localparam int XS_W  = CB_W + QS_W;
    localparam int XH_W  = CB_W + QH_W;

    // Per stage: remainder over remaining numerator / quotient bits
    logic [XS_W-1:0] r_xs  [DEPTH];
    logic [CB_W-1:0] r_ds  [DEPTH];
    logic [XH_W-1:0] r_xh  [DEPTH];
    logic [CB_W-1:0] r_dh  [DEPTH];
    t_tag            r_tag [DEPTH];
    logic [DEPTH-1:0] r_vld;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        logic [XS_W-1:0] src_xs;
        logic [CB_W-1:0] src_ds;
        logic [XH_W-1:0] src_xh;
        logic [CB_W-1:0] src_dh;
        t_tag            src_tag;
        logic            src_vld;
        logic [XS_W-1:0] n_xs;
        logic [XH_W-1:0] n_xh;

        // Select the stage source
        if (k == 0) begin : g_first
            assign src_xs  = i_num_sat;
            assign src_ds  = i_den_sat;
            assign src_xh  = i_num_hue;
            assign src_dh  = i_den_hue;
            assign src_tag = i_tag;
            assign src_vld = i_valid;
        end else begin : g_next
            assign src_xs  = r_xs[k-1];
            assign src_ds  = r_ds[k-1];
            assign src_xh  = r_xh[k-1];
            assign src_dh  = r_dh[k-1];
            assign src_tag = r_tag[k-1];
            assign src_vld = r_vld[k-1];
        end

        // Saturation: one restoring step, or hold once all bits are out
        if (k < QS_W) begin : g_sat_step
            logic [CB_W:0] top_s;
            logic [CB_W:0] sub_s;
            logic          ge_s;
            assign top_s = src_xs[XS_W-1:QS_W-1];
            assign sub_s = top_s - {1'b0, src_ds};
            assign ge_s  = (top_s >= {1'b0, src_ds});
            assign n_xs  = ge_s ? {sub_s[CB_W-1:0], src_xs[QS_W-2:0], 1'b1}
                                : {top_s[CB_W-1:0], src_xs[QS_W-2:0], 1'b0};
        end else begin : g_sat_hold
            assign n_xs = src_xs;
        end

        // Hue fraction: one restoring step, or hold
        if (k < QH_W) begin : g_hue_step
            logic [CB_W:0] top_h;
            logic [CB_W:0] sub_h;
            logic          ge_h;
            assign top_h = src_xh[XH_W-1:QH_W-1];
            assign sub_h = top_h - {1'b0, src_dh};
            assign ge_h  = (top_h >= {1'b0, src_dh});
            assign n_xh  = ge_h ? {sub_h[CB_W-1:0], src_xh[QH_W-2:0], 1'b1}
                                : {top_h[CB_W-1:0], src_xh[QH_W-2:0], 1'b0};
        end else begin : g_hue_hold
            assign n_xh = src_xh;
        end

        // Advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= src_vld;
            end
        end

        // Advance the payload
        always_ff @(posedge i_clk) begin
            r_xs[k]  <= n_xs;
            r_ds[k]  <= src_ds;
            r_xh[k]  <= n_xh;
            r_dh[k]  <= src_dh;
            r_tag[k] <= src_tag;
        end
    end

    assign o_valid    = r_vld[DEPTH-1];
    assign o_quot_sat = r_xs[DEPTH-1][QS_W-1:0];
    assign o_quot_hue = r_xh[DEPTH-1][QH_W-1:0];
    assign o_tag      = r_tag[DEPTH-1];

endmodule

>>> rtl/rgb_to_hsv_convert.sv
// RGB to HSV pixel converter.
// Input channel: drive a pixel on i_pixel with start high; it is taken at
// the rising edge where start is high and busy is low. busy never rises, so
// one pixel can be taken in every clock cycle.
// Output channel: o_done is high for exactly one cycle with the converted
// pixel on o_result (hue in 1/64 degree, saturation scaled to full scale,
// brightness as the largest component). The receiver cannot hold results
// off and must take each one in its cycle.
// Pipeline: one input register, one max/min/sector stage, twelve divider
// stages (one quotient bit of the hue fraction per stage, the longer of
// the two dividers) and one output register. Throughput is one pixel per
// cycle.
// Results leave in the order the pixels entered.
// Reset: a synchronous low i_rst_n clears every valid bit in the pipeline,
// so items in flight are dropped and no strobe follows until new items
// arrive.
module rgb_to_hsv_convert (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rgbhsv_pkg::t_pixel i_pixel,
    output logic               busy,
    output logic               o_done,
    output rgbhsv_pkg::t_hsv   o_result
);
    import rgbhsv_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int HF = HUE_FRACTION_BITS;
    localparam int QH = HUE_QUOT_BITS;
    localparam logic [HUE_BITS-1:0] HUE_TURN  = HUE_BITS'(360 * (1 << HF));
    localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(120 * (1 << HF));
    localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(240 * (1 << HF));

    // Stage 1: input register
    logic   r_v1;
    t_pixel r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= i_pixel;
    end

    // Stage 2: max, min, sector and signed difference
    logic [CB-1:0] max_c, min_c, diff_a, diff_b, n_mag, n_spread;
    t_sector       sec;
    t_tag          n_tag;

    always_comb begin
        max_c = r_pix.red;
        min_c = r_pix.red;
        if (r_pix.green > max_c) max_c = r_pix.green;
        if (r_pix.blue  > max_c) max_c = r_pix.blue;
        if (r_pix.green < min_c) min_c = r_pix.green;
        if (r_pix.blue  < min_c) min_c = r_pix.blue;
        if (r_pix.red == max_c) begin
            sec    = SEC_RED;
            diff_a = r_pix.green;
            diff_b = r_pix.blue;
        end else if (r_pix.green == max_c) begin
            sec    = SEC_GREEN;
            diff_a = r_pix.blue;
            diff_b = r_pix.red;
        end else begin
            sec    = SEC_BLUE;
            diff_a = r_pix.red;
            diff_b = r_pix.green;
        end
        n_spread     = max_c - min_c;
        n_tag.grey   = (n_spread == '0);
        n_tag.sector = sec;
        n_tag.neg    = (diff_a < diff_b);
        n_tag.max_c  = max_c;
        n_mag        = n_tag.neg ? (diff_b - diff_a) : (diff_a - diff_b);
    end

    logic          r_v2;
    t_tag          r_tag2;
    logic [CB-1:0] r_spread, r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag2   <= n_tag;
        r_spread <= n_spread;
        r_mag    <= n_mag;
    end

    // Numerators: full scale times spread, and 60 * 2^HF times magnitude
    logic [2*CB-1:0]  num_sat;
    logic [CB+5:0]    mag60;
    logic [CB+QH-1:0] num_hue;

    assign num_sat = {r_spread, {CB{1'b0}}} - {{CB{1'b0}}, r_spread};
    assign mag60   = {r_mag, 6'b0} - {4'b0, r_mag, 2'b0};
    assign num_hue = {mag60, {HF{1'b0}}};

    // Pipelined dividers
    logic          dv_valid;
    logic [CB-1:0] q_sat;
    logic [QH-1:0] q_hue;
    t_tag          dv_tag;

    rgbhsv_div #(
        .CB_W (CB),
        .QS_W (CB),
        .QH_W (QH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_num_sat  (num_sat),
        .i_den_sat  (r_tag2.max_c),
        .i_num_hue  (num_hue),
        .i_den_hue  (r_spread),
        .i_tag      (r_tag2),
        .o_valid    (dv_valid),
        .o_quot_sat (q_sat),
        .o_quot_hue (q_hue),
        .o_tag      (dv_tag)
    );

    // Final stage: add the sector offset and wrap negative red hues
    logic [HUE_BITS-1:0] q_ext, n_hue;
    t_hsv                n_result;

    assign q_ext = HUE_BITS'(q_hue);

    always_comb begin
        unique case (dv_tag.sector)
            SEC_RED: begin
                if (dv_tag.neg && q_ext != '0) begin
                    n_hue = HUE_TURN - q_ext;
                end else begin
                    n_hue = q_ext;
                end
            end
            SEC_GREEN: n_hue = dv_tag.neg ? (HUE_GREEN - q_ext) : (HUE_GREEN + q_ext);
            SEC_BLUE:  n_hue = dv_tag.neg ? (HUE_BLUE - q_ext) : (HUE_BLUE + q_ext);
            default:   n_hue = '0;
        endcase
        n_result.hue        = dv_tag.grey ? '0 : n_hue;
        n_result.saturation = dv_tag.grey ? '0 : q_sat;
        n_result.brightness = dv_tag.max_c;
    end

    logic r_done;
    t_hsv r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> rtl/rgbhsv_checker.sv
module rgbhsv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input rgbhsv_pkg::t_pixel i_pixel,
    input logic               busy,
    input logic               o_done,
    input rgbhsv_pkg::t_hsv   o_result
);
    import rgbhsv_pkg::*;

    localparam int LATENCY = 15;
    localparam logic [HUE_BITS-1:0] HUE_TURN = HUE_BITS'(360 * (1 << HUE_FRACTION_BITS));

    // Count cycles since reset, saturating at the latency
    logic [4:0] r_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != 5'(LATENCY)) begin
            r_warm <= r_warm + 5'd1;
        end
    end

    // Every accepted item leaves exactly after the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == 5'(LATENCY)) |-> (o_done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match accepted items");

    // Hue stays inside one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.hue < HUE_TURN))
        else $error("hue out of range");

    // Black pixel gives no colour
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.brightness == '0) |->
            (o_result.saturation == '0 && o_result.hue == '0))
        else $error("black pixel carries colour");

    // Zero saturation means a grey pixel, so hue is zero too
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturation == '0) |-> (o_result.hue == '0))
        else $error("grey pixel carries hue");

endmodule

bind rgb_to_hsv_convert rgbhsv_checker u_checker (.*);
